FILE: sv/rbm_pkg.sv
`timescale 1ns / 1ps

package rbm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STAGES  = 34;
    localparam int DIV_STAGES   = 32;
    localparam int NORM_MSB     = 39;
    localparam int QW           = 66;
    localparam int WB           = QW + 32;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] NEG_PI_Q28  = -34'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

    // register select on paddr[2]
    localparam logic REG_RANGE_MEAN   = 1'b0;
    localparam logic REG_BEARING_MEAN = 1'b1;

    localparam logic signed [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
        32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072, 32'sd65536,
        32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024,
        32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8,
        32'sd4, 32'sd2
    };

    typedef struct packed {
        logic signed [31:0] head;
        logic               degen;
        logic               dx_pos;
        logic               dx_neg;
        logic               dy_pos;
        logic               dy_neg;
    } t_meta;

    typedef struct packed {
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [31:0] z;
    } t_cordic;

    typedef struct packed {
        logic [67:0]   rem;
        logic [33:0]   root;
        logic [QW-1:0] q;
        t_cordic       cd;
        t_meta         mt;
        logic [32:0]   ax;
        logic [32:0]   ay;
    } t_rs;

    typedef struct packed {
        logic [65:0]        rem_rx;
        logic [65:0]        rem_ry;
        logic [WB-1:0]      rem_bx;
        logic [WB-1:0]      rem_by;
        logic [31:0]        mag_rx;
        logic [31:0]        mag_ry;
        logic [31:0]        mag_bx;
        logic [31:0]        mag_by;
        logic [33:0]        root;
        logic [QW-1:0]      q;
        logic signed [33:0] brg;
        logic               ov_bx;
        logic               ov_by;
        t_meta              mt;
    } t_dv;

    function automatic logic [31:0] sat_add(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sh080000000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] signed_mag(input logic [31:0] mag, input logic neg);
        if (neg) begin
            if (mag > 32'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'(-mag);
        end
        if (mag[31]) begin
            return 32'h7FFF_FFFF;
        end
        return mag;
    endfunction

endpackage

FILE: sv/range_bearing_measurement_model.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the whole pipeline advances while the output
// register is empty or being taken.
// Stages: 4 front stages, 34 square root / CORDIC stages, 1 bearing stage,
// 32 divider stages and the output register. Reset clears valid bits and the noise means.

module range_bearing_measurement_model (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // robot_x, robot_y, robot_heading, landmark_x, landmark_y
    input  logic [159:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // expected_range, expected_bearing, d_range_dx, d_range_dy, d_bearing_dx, d_bearing_dy
    output logic [191:0] o_m_tdata,
    // degenerate
    output logic         o_m_tuser,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int SQ = rbm_pkg::SQRT_STAGES;
    localparam int DV = rbm_pkg::DIV_STAGES;
    localparam int FB = rbm_pkg::FRAC_BITS;
    localparam int WB = rbm_pkg::WB;

    logic w_en;

    logic signed [31:0] r_range_mean;
    logic signed [31:0] r_bearing_mean;

    // configuration
    assign o_pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mean   <= '0;
            r_bearing_mean <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2] == rbm_pkg::REG_BEARING_MEAN) begin
                r_bearing_mean <= i_pwdata;
            end else begin
                r_range_mean <= i_pwdata;
            end
        end
    end
    assign o_prdata = (i_paddr[2] == rbm_pkg::REG_RANGE_MEAN) ? r_range_mean : r_bearing_mean;

    logic r_out_valid;
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // stage A: offsets
    logic               r_a_v;
    logic signed [32:0] r_a_dx, r_a_dy;
    logic signed [31:0] r_a_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_s_tvalid;
        end
        if (w_en) begin
            r_a_dx   <= 33'($signed(i_s_tdata[127:96])) - 33'($signed(i_s_tdata[31:0]));
            r_a_dy   <= 33'($signed(i_s_tdata[159:128])) - 33'($signed(i_s_tdata[63:32]));
            r_a_head <= i_s_tdata[95:64];
        end
    end

    // stage B: magnitudes and flags
    logic               r_b_v;
    logic [32:0]        r_b_ax, r_b_ay;
    logic signed [32:0] r_b_dx, r_b_dy;
    rbm_pkg::t_meta     r_b_mt;
    rbm_pkg::t_meta     n_b_mt;

    always_comb begin
        n_b_mt.head   = r_a_head;
        n_b_mt.degen  = (r_a_dx == '0) && (r_a_dy == '0);
        n_b_mt.dx_pos = !r_a_dx[32] && (r_a_dx != '0);
        n_b_mt.dx_neg = r_a_dx[32];
        n_b_mt.dy_pos = !r_a_dy[32] && (r_a_dy != '0);
        n_b_mt.dy_neg = r_a_dy[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
        if (w_en) begin
            r_b_ax <= r_a_dx[32] ? 33'(-r_a_dx) : 33'(r_a_dx);
            r_b_ay <= r_a_dy[32] ? 33'(-r_a_dy) : 33'(r_a_dy);
            r_b_dx <= r_a_dx;
            r_b_dy <= r_a_dy;
            r_b_mt <= n_b_mt;
        end
    end

    // stage C: squares and normalising shift
    logic               r_c_v;
    logic [65:0]        r_c_sqx, r_c_sqy;
    logic [5:0]         r_c_sh;
    logic [32:0]        r_c_ax, r_c_ay;
    logic signed [32:0] r_c_dx, r_c_dy;
    rbm_pkg::t_meta     r_c_mt;
    logic [32:0]        w_or;
    logic [5:0]         n_c_msb;

    assign w_or = r_b_ax | r_b_ay;
    always_comb begin
        n_c_msb = '0;
        for (int i = 0; i < 33; i++) begin
            if (w_or[i]) begin
                n_c_msb = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
        if (w_en) begin
            r_c_sqx <= 66'(r_b_ax) * 66'(r_b_ax);
            r_c_sqy <= 66'(r_b_ay) * 66'(r_b_ay);
            r_c_sh  <= 6'(rbm_pkg::NORM_MSB) - n_c_msb;
            r_c_ax  <= r_b_ax;
            r_c_ay  <= r_b_ay;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_mt  <= r_b_mt;
        end
    end

    // stage D feeds the root / CORDIC pipeline at index 0
    logic         r_rs_v [0:SQ];
    rbm_pkg::t_rs r_rs   [0:SQ];
    rbm_pkg::t_rs n_d;
    logic signed [43:0] w_d_x, w_d_y;

    assign w_d_x = 44'(r_c_dx);
    assign w_d_y = 44'(r_c_dy);

    always_comb begin
        n_d.rem  = 68'(r_c_sqx) + 68'(r_c_sqy);
        n_d.q    = 66'(r_c_sqx + r_c_sqy);
        n_d.root = '0;
        n_d.cd.x = w_d_x <<< r_c_sh;
        n_d.cd.y = w_d_y <<< r_c_sh;
        n_d.cd.z = '0;
        n_d.mt   = r_c_mt;
        n_d.ax   = r_c_ax;
        n_d.ay   = r_c_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_v[0] <= 1'b0;
        end else if (w_en) begin
            r_rs_v[0] <= r_c_v;
        end
        if (w_en) begin
            r_rs[0] <= n_d;
        end
    end

    // one root bit per stage; the first stage folds the left half-plane and the CORDIC steps follow, one per stage
    for (genvar k = 0; k < SQ; k++) begin : g_rs
        localparam int BIT = SQ - 1 - k;
        rbm_pkg::t_rs     w_nx;
        rbm_pkg::t_cordic w_cd;
        logic [67:0]      w_trial;
        logic signed [43:0] w_x, w_y;

        assign w_x = r_rs[k].cd.x;
        assign w_y = r_rs[k].cd.y;

        if (k == 0) begin : g_pre
            always_comb begin
                w_cd = r_rs[k].cd;
                if (w_x < 0) begin
                    if (w_y >= 0) begin
                        w_cd.x = w_y;
                        w_cd.y = -w_x;
                        w_cd.z = rbm_pkg::HALF_PI_Q28;
                    end else begin
                        w_cd.x = -w_y;
                        w_cd.y = w_x;
                        w_cd.z = -rbm_pkg::HALF_PI_Q28;
                    end
                end
            end
        end else if (k <= rbm_pkg::CORDIC_STEPS) begin : g_it
            localparam int I = k - 1;
            logic signed [43:0] w_xs, w_ys;
            assign w_xs = w_x >>> I;
            assign w_ys = w_y >>> I;
            always_comb begin
                if (w_y >= 0) begin
                    w_cd.x = w_x + w_ys;
                    w_cd.y = w_y - w_xs;
                    w_cd.z = r_rs[k].cd.z + rbm_pkg::ATAN_TAB[I];
                end else begin
                    w_cd.x = w_x - w_ys;
                    w_cd.y = w_y + w_xs;
                    w_cd.z = r_rs[k].cd.z - rbm_pkg::ATAN_TAB[I];
                end
            end
        end else begin : g_hold
            assign w_cd = r_rs[k].cd;
        end

        assign w_trial = (68'(r_rs[k].root) << (BIT + 1)) | (68'(1) << (2 * BIT));

        always_comb begin
            w_nx    = r_rs[k];
            w_nx.cd = w_cd;
            if (r_rs[k].rem >= w_trial) begin
                w_nx.rem  = r_rs[k].rem - w_trial;
                w_nx.root = r_rs[k].root | (34'(1) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rs_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_rs_v[k+1] <= r_rs_v[k];
            end
            if (w_en) begin
                r_rs[k+1] <= w_nx;
            end
        end
    end

    // stage F: bearing and divider set-up, index 0 of the divider pipeline
    logic         r_dv_v [0:DV];
    rbm_pkg::t_dv r_dv   [0:DV];
    rbm_pkg::t_dv n_f;
    rbm_pkg::t_rs w_f_in;
    logic signed [31:0] w_f_a;
    logic signed [33:0] w_f_b1, w_f_habs;
    logic [WB-1:0]      w_f_qs;

    assign w_f_in   = r_rs[SQ];
    assign w_f_a    = w_f_in.mt.degen ? 32'sd0 : w_f_in.cd.z;
    assign w_f_b1   = 34'(w_f_a) - 34'(w_f_in.mt.head);
    assign w_f_habs = w_f_in.mt.head[31] ? -34'(w_f_in.mt.head) : 34'(w_f_in.mt.head);
    assign w_f_qs   = WB'(w_f_in.q) << 32;

    always_comb begin
        n_f.rem_rx = 66'(w_f_in.ax) << 30;
        n_f.rem_ry = 66'(w_f_in.ay) << 30;
        n_f.rem_bx = WB'(w_f_in.ay) << (2 * FB);
        n_f.rem_by = WB'(w_f_in.ax) << (2 * FB);
        n_f.mag_rx = '0;
        n_f.mag_ry = '0;
        n_f.mag_bx = '0;
        n_f.mag_by = '0;
        n_f.root   = w_f_in.root;
        n_f.q      = w_f_in.q;
        n_f.ov_bx  = (WB'(w_f_in.ay) << (2 * FB)) >= w_f_qs;
        n_f.ov_by  = (WB'(w_f_in.ax) << (2 * FB)) >= w_f_qs;
        n_f.mt     = w_f_in.mt;
        // wrap past pi: fall back to the absolute heading
        if (w_f_b1 >= rbm_pkg::PI_Q28 || w_f_b1 <= rbm_pkg::NEG_PI_Q28) begin
            n_f.brg = 34'(w_f_a) - w_f_habs;
        end else begin
            n_f.brg = w_f_b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_rs_v[SQ];
        end
        if (w_en) begin
            r_dv[0] <= n_f;
        end
    end

    // one quotient bit per stage for all four divisions
    for (genvar j = 0; j < DV; j++) begin : g_dv
        localparam int BIT = DV - 1 - j;
        rbm_pkg::t_dv  w_nx;
        logic [65:0]   w_den_r;
        logic [WB-1:0] w_den_q;

        assign w_den_r = 66'(r_dv[j].root) << BIT;
        assign w_den_q = WB'(r_dv[j].q) << BIT;

        always_comb begin
            w_nx = r_dv[j];
            if (r_dv[j].rem_rx >= w_den_r) begin
                w_nx.rem_rx      = r_dv[j].rem_rx - w_den_r;
                w_nx.mag_rx[BIT] = 1'b1;
            end
            if (r_dv[j].rem_ry >= w_den_r) begin
                w_nx.rem_ry      = r_dv[j].rem_ry - w_den_r;
                w_nx.mag_ry[BIT] = 1'b1;
            end
            if (r_dv[j].rem_bx >= w_den_q) begin
                w_nx.rem_bx      = r_dv[j].rem_bx - w_den_q;
                w_nx.mag_bx[BIT] = 1'b1;
            end
            if (r_dv[j].rem_by >= w_den_q) begin
                w_nx.rem_by      = r_dv[j].rem_by - w_den_q;
                w_nx.mag_by[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            if (w_en) begin
                r_dv[j+1] <= w_nx;
            end
        end
    end

    // output register
    rbm_pkg::t_dv w_o;
    logic [31:0]  n_rng, n_brg, n_drx, n_dry, n_dbx, n_dby;
    logic [191:0] r_out_data;
    logic         r_out_user;

    assign w_o = r_dv[DV];

    always_comb begin
        n_rng = rbm_pkg::sat_add(36'(w_o.root) + 36'(r_range_mean));
        n_brg = rbm_pkg::sat_add(36'(w_o.brg) + 36'(r_bearing_mean));
        n_drx = '0;
        n_dry = '0;
        n_dbx = '0;
        n_dby = '0;
        if (!w_o.mt.degen) begin
            n_drx = rbm_pkg::signed_mag(w_o.mag_rx, w_o.mt.dx_pos);
            n_dry = rbm_pkg::signed_mag(w_o.mag_ry, w_o.mt.dy_pos);
            n_dbx = rbm_pkg::signed_mag(w_o.ov_bx ? 32'hFFFF_FFFF : w_o.mag_bx, w_o.mt.dy_neg);
            n_dby = rbm_pkg::signed_mag(w_o.ov_by ? 32'hFFFF_FFFF : w_o.mag_by, w_o.mt.dx_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_v[DV];
        end
        if (w_en) begin
            r_out_data <= {n_dby, n_dbx, n_dry, n_drx, n_brg, n_rng};
            r_out_user <= w_o.mt.degen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[191:64] == '0))
        else $error("degenerate word carries non-zero derivatives");

    a_drx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[95:64]) <= 32'sh4000_0000
                     && $signed(o_m_tdata[95:64]) >= -32'sh4000_0000))
        else $error("d_range_dx beyond unit magnitude");

    a_dy_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[127] && o_m_tdata[159]))
        else $error("d_range_dy and d_bearing_dx both negative");
`endif

endmodule

FILE: bench/range_bearing_measurement_model_test.sv
`timescale 1ns / 1ps

module range_bearing_measurement_model_test;

    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint NORM_LIMIT  = 64'sd549755813888;
    localparam int     PIPE_DEPTH  = 72;
    localparam logic [2:0] ADDR_RANGE_MEAN   = 3'd0;
    localparam logic [2:0] ADDR_BEARING_MEAN = 3'd4;

    localparam longint ARCTAN_STEP [0:27] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic signed [31:0] rng;
        logic signed [31:0] brg;
        logic signed [31:0] drx;
        logic signed [31:0] dry;
        logic signed [31:0] dbx;
        logic signed [31:0] dby;
        logic               degen;
    } t_meas;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    t_meas  pending_meas[$];
    longint range_mean;
    longint bearing_mean;
    bit     idle_on;
    int     stall_left;
    int     fail_count;
    int     words_sent;
    int     words_checked;

    range_bearing_measurement_model u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
        if (v < -64'sh80000000) return -64'sh80000000;
        return v;
    endfunction

    function automatic logic [31:0] signed_quot(logic [127:0] mag, bit neg);
        longint v;
        v = longint'(mag[63:0]);
        return 32'(sat32(neg ? -v : v));
    endfunction

    function automatic t_meas predict_measurement(logic [159:0] w);
        t_meas  e;
        longint dx, dy, head, x, y, z, t, m, xs, ys, brg;
        logic [127:0] ax, ay, q, c, root, num;
        dx   = longint'($signed(w[127:96])) - longint'($signed(w[31:0]));
        dy   = longint'($signed(w[159:128])) - longint'($signed(w[63:32]));
        head = longint'($signed(w[95:64]));
        ax   = dx < 0 ? -dx : dx;
        ay   = dy < 0 ? -dy : dy;
        q    = ax * ax + ay * ay;
        root = '0;
        for (int k = 33; k >= 0; k--) begin
            c = root | (128'd1 << k);
            if (c * c <= q) root = c;
        end
        // vectoring arctangent: normalise, fold the left half-plane, rotate
        z = 0;
        if (dx != 0 || dy != 0) begin
            x = dx;
            y = dy;
            forever begin
                m = x < 0 ? -x : x;
                t = y < 0 ? -y : y;
                if (t > m) m = t;
                if (m >= NORM_LIMIT) break;
                x = x * 2;
                y = y * 2;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q28;
                end else begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q28;
                end
            end
            for (int i = 0; i < 28; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_STEP[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_STEP[i];
                end
            end
        end
        brg = z - head;
        if ((brg < 0 ? -brg : brg) >= PI_Q28) brg = z - (head < 0 ? -head : head);
        e.rng   = 32'(sat32(longint'(root[63:0]) + range_mean));
        e.brg   = 32'(sat32(brg + bearing_mean));
        e.degen = (dx == 0 && dy == 0);
        e.drx = '0;
        e.dry = '0;
        e.dbx = '0;
        e.dby = '0;
        if (!e.degen) begin
            e.drx = signed_quot((ax << 30) / root, dx > 0);
            e.dry = signed_quot((ay << 30) / root, dy > 0);
            num = ay << 32;
            e.dbx = signed_quot(num >= (q << 32) ? 128'hFFFF_FFFF : num / q, dy < 0);
            num = ax << 32;
            e.dby = signed_quot(num >= (q << 32) ? 128'hFFFF_FFFF : num / q, dx > 0);
        end
        return e;
    endfunction

    function automatic logic [159:0] pack_pose(logic [31:0] rx, logic [31:0] ry,
                                               logic [31:0] hd, logic [31:0] lx,
                                               logic [31:0] ly);
        return {ly, lx, hd, ry, rx};
    endfunction

    function automatic logic [159:0] random_pose();
        logic [31:0] rx, ry, hd, off_x, off_y;
        int sel;
        rx  = $urandom();
        ry  = $urandom();
        sel = $urandom_range(0, 9);
        hd  = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 1686629714)) - 32'd843314857;
        if (sel == 0) return pack_pose(rx, ry, hd, rx, ry);
        if (sel <= 3) return pack_pose(rx, ry, hd, $urandom(), $urandom());
        // nearby landmark: offsets of random size keep the derivatives in range
        off_x = $urandom() >>> $urandom_range(0, 31);
        off_y = $urandom() >>> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) off_x = -off_x;
        if ($urandom_range(0, 1)) off_y = -off_y;
        return pack_pose(rx, ry, hd, rx + off_x, ry + off_y);
    endfunction

    task automatic send_pose(logic [159:0] w);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge i_clk); while (!s_tready);
        pending_meas.push_back(predict_measurement(w));
        words_sent++;
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        while (pending_meas.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_RANGE_MEAN) range_mean = longint'($signed(val));
        else bearing_mean = longint'($signed(val));
    endtask

    task automatic test_directed();
        logic [31:0] maxv, minv;
        maxv = 32'h7FFF_FFFF;
        minv = 32'h8000_0000;
        // coincident robot and landmark, heading at both ends
        send_pose(pack_pose(0, 0, 0, 0, 0));
        send_pose(pack_pose(maxv, minv, maxv, maxv, minv));
        send_pose(pack_pose(minv, maxv, minv, minv, maxv));
        // single-step offsets along each axis and into the first and third quadrants
        send_pose(pack_pose(0, 0, 0, 1, 0));
        send_pose(pack_pose(0, 0, 0, -1, 0));
        send_pose(pack_pose(0, 0, 0, 0, 1));
        send_pose(pack_pose(0, 0, 0, 0, -1));
        send_pose(pack_pose(0, 0, 0, -1, -1));
        send_pose(pack_pose(0, 0, 0, 1, 1));
        // largest offsets: range saturates; the last pose has a unit offset from all-ones robot coordinates
        send_pose(pack_pose(minv, minv, 0, maxv, maxv));
        send_pose(pack_pose(maxv, maxv, 0, minv, minv));
        send_pose(pack_pose(minv, maxv, 0, maxv, minv));
        send_pose(pack_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        // bearing wraps past pi: fall back to absolute heading; the last pose, heading pi, does not wrap
        send_pose(pack_pose(0, 0, -32'sd421657428, -32'sd65536, 32'sd1));
        send_pose(pack_pose(0, 0, 32'sd421657428, -32'sd65536, -32'sd1));
        send_pose(pack_pose(0, 0, minv, 32'sd65536, 0));
        send_pose(pack_pose(0, 0, maxv, -32'sd65536, 0));
        send_pose(pack_pose(0, 0, 32'sd843314857, -32'sd65536, 0));
        // a moderate offset, then alternating-bit patterns
        send_pose(pack_pose(32'sd65536, 32'sd131072, 32'sd268435456, 32'sd327680, -32'sd65536));
        send_pose(pack_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555));
        finish_burst();
    endtask

    task automatic test_noise_means();
        logic [31:0] setting [0:4][0:1];
        setting = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF}, '{32'h8000_0000, 32'h8000_0000},
                    '{32'h7FFF_FFFF, 32'h8000_0000}, '{$urandom(), $urandom()},
                    '{32'h0001_0000, 32'h1000_0000}};
        for (int s = 0; s < 5; s++) begin
            write_reg(ADDR_RANGE_MEAN, setting[s][0]);
            write_reg(ADDR_BEARING_MEAN, setting[s][1]);
            repeat (40) send_pose(random_pose());
            send_pose(pack_pose(0, 0, 32'h8000_0000, 0, 0));
            finish_burst();
        end
        write_reg(ADDR_RANGE_MEAN, 32'd0);
        write_reg(ADDR_BEARING_MEAN, 32'd0);
    endtask

    task automatic test_random_stream();
        write_reg(ADDR_RANGE_MEAN, $urandom() >>> 8);
        write_reg(ADDR_BEARING_MEAN, $urandom() >>> 4);
        for (int n = 0; n < 1650; n++) begin
            if (n == 1350) idle_on = 1'b0;
            send_pose(random_pose());
        end
        finish_burst();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_meas e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_meas.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                e = pending_meas.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== e.rng) begin
                    $error("expected_range: exp %0d got %0d", e.rng, $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tdata[63:32] !== e.brg) begin
                    $error("expected_bearing: exp %0d got %0d", e.brg,
                           $signed(m_tdata[63:32]));
                    fail_count++;
                end
                if (m_tdata[95:64] !== e.drx) begin
                    $error("d_range_dx: exp %0d got %0d", e.drx, $signed(m_tdata[95:64]));
                    fail_count++;
                end
                if (m_tdata[127:96] !== e.dry) begin
                    $error("d_range_dy: exp %0d got %0d", e.dry, $signed(m_tdata[127:96]));
                    fail_count++;
                end
                if (m_tdata[159:128] !== e.dbx) begin
                    $error("d_bearing_dx: exp %0d got %0d", e.dbx,
                           $signed(m_tdata[159:128]));
                    fail_count++;
                end
                if (m_tdata[191:160] !== e.dby) begin
                    $error("d_bearing_dy: exp %0d got %0d", e.dby,
                           $signed(m_tdata[191:160]));
                    fail_count++;
                end
                if (m_tuser !== e.degen) begin
                    $error("degenerate: exp %0d got %0d", e.degen, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        range_mean    = 0;
        bearing_mean  = 0;
        idle_on       = 1'b1;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_noise_means();
        test_random_stream();
        if (pending_meas.size() != 0) begin
            $error("%0d results never arrived", pending_meas.size());
            fail_count++;
        end
        $display("Covered %0d poses (directed, noise-mean extremes, random stream), %0d checked.",
                 words_sent, words_checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
